/* hdl/dkcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkcs_pkg
// Shared types and constants for the coefficient smoother.
// ----------------------------------------------------------------------------
package dkcs_pkg;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned NUM_LANES  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned MAX_POINTS = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PROC_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MVAR_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MVAR_B   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MVAR_C   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_STEP = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    L_IDLE, L_PP, L_PPH, L_PPL, L_PRED, L_RM, L_RDIV, L_KSET, L_KDIV,
    L_CORR, L_VAR, L_DONE
  } lane_state_t;

  typedef struct packed {
    logic                    seeded;
    logic                    meas_valid;
    logic [DATA_W-1:0]       step;
    logic [CNT_W-1:0]        inl;
    logic [CNT_W-1:0]        min_inl;
  } lane_cmd_t;
endpackage
`default_nettype wire

/* hdl/dkcs_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkcs_lane
// One scalar Kalman channel: predict, scale R, divide for gain, update.
// Multi-cycle sequencer with a shared 32x32 multiplier and restoring divider.
// ----------------------------------------------------------------------------
module dkcs_lane (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire dkcs_pkg::lane_cmd_t  cmd,
  input  wire [31:0]                proc_noise,
  input  wire [31:0]                meas_var,
  input  wire signed [31:0]         meas,
  output logic                      done,
  output logic signed [31:0]        est,
  output logic [31:0]               var_o
);
  import dkcs_pkg::*;

  lane_state_t st_r, st_nxt;
  logic signed [31:0] est_r;
  logic [31:0] var_r;
  logic [63:0] pp_r, hi_r;
  logic [63:0] prod;
  logic [31:0] ma, mb;
  logic [31:0] q_r;
  logic [31:0] r_r;
  logic [5:0]  cnt_r;
  // divider: numerator shift reg, remainder, quotient
  logic [63:0] num_r;
  logic [32:0] rem_r;
  logic [32:0] den_r;
  logic [31:0] quo_r;
  logic [31:0] k_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic [33:0] rem_sh;
  logic [33:0] diff;
  logic [33:0] rem_nxt;
  logic [31:0] quo_nxt;
  logic [64:0] q65;
  logic [32:0] vsum;
  logic [32:0] dz;
  logic [6:0]  m_w;
  logic        scale_w;

  assign rem_sh  = {rem_r, num_r[63]};
  assign diff    = rem_sh - {1'b0, den_r};
  assign rem_nxt = diff[33] ? rem_sh : diff;
  assign quo_nxt = {quo_r[30:0], ~diff[33]};
  assign m_w     = (cmd.min_inl > 7'd1) ? cmd.min_inl : 7'd1;
  assign scale_w = (cmd.inl > m_w);

  always_comb begin
    case (st_r)
      L_PP:   begin ma = proc_noise;  mb = proc_noise;   end
      L_PPH:  begin ma = pp_r[63:32]; mb = cmd.step;     end
      L_PPL:  begin ma = pp_r[31:0];  mb = cmd.step;     end
      L_RM:   begin ma = meas_var;    mb = {25'd0, m_w}; end
      L_CORR: begin ma = k_r;         mb = mag_r;        end
      L_VAR:  begin ma = var_r;       mb = 32'h8000_0000 - k_r; end
      default: begin ma = var_r;      mb = var_r;        end
    endcase
  end
  assign prod = ma * mb;
  assign q65  = {1'b0, hi_r} + {33'd0, prod[63:32]};
  assign vsum = {1'b0, var_r} + {1'b0, q_r};
  assign dz   = {meas[31], meas} - {est_r[31], est_r};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE: if (start) begin
        st_nxt = cmd.seeded ? L_PP : L_DONE;
      end
      L_PP:   st_nxt = L_PPH;
      L_PPH:  st_nxt = L_PPL;
      L_PPL:  st_nxt = L_PRED;
      L_PRED: st_nxt = cmd.meas_valid ? L_RM : L_DONE;
      L_RM:   st_nxt = scale_w ? L_RDIV : L_KSET;
      L_RDIV: if (cnt_r == 6'd0) st_nxt = L_KSET;
      L_KSET: st_nxt = L_KDIV;
      L_KDIV: if (cnt_r == 6'd0) st_nxt = L_CORR;
      L_CORR: st_nxt = L_VAR;
      L_VAR:  st_nxt = L_DONE;
      L_DONE: st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  assign done  = (st_r == L_DONE);
  assign est   = est_r;
  assign var_o = var_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= L_IDLE;
      est_r <= '0;
      var_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        L_IDLE: if (start && !cmd.seeded && cmd.meas_valid) begin
          est_r <= meas;
          var_r <= meas_var;
        end
        L_PP:  pp_r <= prod;
        L_PPH: hi_r <= prod;
        // (hi + lo>>32) >> 16, saturate to 32 bits
        L_PPL: q_r <= (q65[64:48] != 17'd0) ? 32'hFFFF_FFFF : q65[47:16];
        L_PRED: var_r <= vsum[32] ? 32'hFFFF_FFFF : vsum[31:0];
        L_RM: begin
          r_r   <= meas_var;
          num_r <= prod;
          den_r <= {26'd0, cmd.inl};
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= 6'd63;
        end
        L_RDIV: begin
          num_r <= {num_r[62:0], 1'b0};
          rem_r <= rem_nxt[32:0];
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) r_r <= quo_nxt;
        end
        L_KSET: begin
          num_r <= {1'b0, var_r, 31'd0};
          den_r <= {1'b0, var_r} + {1'b0, r_r};
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= 6'd63;
        end
        L_KDIV: begin
          num_r <= {num_r[62:0], 1'b0};
          rem_r <= rem_nxt[32:0];
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            k_r   <= (den_r == 33'd0) ? 32'd0 : quo_nxt;
            neg_r <= dz[32];
            mag_r <= dz[32] ? 32'(33'd0 - dz) : dz[31:0];
          end
        end
        // correction never exceeds |z - x|, so 32 bits hold it
        L_CORR: est_r <= neg_r ? (est_r - prod[62:31]) : (est_r + prod[62:31]);
        L_VAR: var_r <= prod[62:31];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/diagonal_kalman_coef_smoother_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diagonal_kalman_coef_smoother_core
// Three scalar random-walk Kalman filters smoothing quadratic coefficients.
// ----------------------------------------------------------------------------
// One item at a time: in_ready is high only while the block is idle. out_valid
// rises once all lanes finish. A measurement that updates a seeded filter with
// inlier-scaled noise runs two 64-step restoring divisions in each lane (for
// the scaled noise and the gain); unscaled noise runs the gain division only; a
// step without a measurement only predicts; before seeding the lanes only take
// in the measurement. in_ready comes back right after the result transfer. The
// three lanes run in lockstep; the merge stage holds the result register until
// it is taken.
module diagonal_kalman_coef_smoother_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire [2:0]            cfg_index,
  input  wire [31:0]           cfg_data,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [31:0]           in_time_step,
  input  wire                  in_meas_valid,
  input  wire signed [31:0]    in_meas_a,
  input  wire signed [31:0]    in_meas_b,
  input  wire signed [31:0]    in_meas_c,
  input  wire [6:0]            in_inlier_count,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic signed [31:0]   out_smooth_a,
  output logic signed [31:0]   out_smooth_b,
  output logic signed [31:0]   out_smooth_c,
  output logic [31:0]          out_var_a_out,
  output logic [31:0]          out_var_b_out,
  output logic [31:0]          out_var_c_out,
  output logic                 out_filter_ready
);
  import dkcs_pkg::*;

  logic [31:0] cfg_r [8];
  ctrl_state_t st_r, st_nxt;
  lane_cmd_t   cmd_r;
  logic signed [31:0] z_r [3];
  logic seeded_r;
  logic [2:0] done_w;
  logic signed [31:0] est_w [3];
  logic [31:0] var_w [3];
  logic start_r;
  logic seed_w;

  assign seed_w = seeded_r || cmd_r.meas_valid;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    dkcs_lane u_lane (
      .clk(clk), .rst_n(rst_n), .start(start_r), .cmd(cmd_r),
      .proc_noise(cfg_r[g]), .meas_var(cfg_r[3+g]), .meas(z_r[g]),
      .done(done_w[g]), .est(est_w[g]), .var_o(var_w[g])
    );
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_BUSY;
      ST_BUSY: if (&done_w) st_nxt = ST_OUT;
      ST_OUT:  if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (st_r == ST_IDLE);
    out_valid = (st_r == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      seeded_r <= 1'b0;
      start_r  <= 1'b0;
      for (int i = 0; i < 8; i++) cfg_r[i] <= (3'(i) == REG_MIN_INL) ? 32'd1 : 32'd0;
      out_smooth_a     <= '0;
      out_smooth_b     <= '0;
      out_smooth_c     <= '0;
      out_var_a_out    <= '0;
      out_var_b_out    <= '0;
      out_var_c_out    <= '0;
      out_filter_ready <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      start_r <= in_valid && in_ready;
      if (cfg_we) begin
        if (cfg_index == REG_MIN_INL) cfg_r[cfg_index] <= {25'd0, cfg_data[6:0]};
        else cfg_r[cfg_index] <= cfg_data;
      end
      if (in_valid && in_ready) begin
        cmd_r <= '{seeded:     seeded_r,
                   meas_valid: in_meas_valid,
                   step:       (in_time_step == 32'd0) ? cfg_r[REG_DEF_STEP] : in_time_step,
                   inl:        in_inlier_count,
                   min_inl:    cfg_r[REG_MIN_INL][6:0]};
        z_r[0] <= in_meas_a;
        z_r[1] <= in_meas_b;
        z_r[2] <= in_meas_c;
      end
      if (st_r == ST_BUSY && (&done_w)) begin
        if (cmd_r.meas_valid) seeded_r <= 1'b1;
        out_smooth_a <= seed_w ? est_w[0] : z_r[0];
        out_smooth_b <= seed_w ? est_w[1] : z_r[1];
        out_smooth_c <= seed_w ? est_w[2] : z_r[2];
        out_var_a_out <= var_w[0];
        out_var_b_out <= var_w[1];
        out_var_c_out <= var_w[2];
        out_filter_ready <= seed_w;
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/dkcs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkcs_checker
// Port-level checks for the coefficient smoother.
// ----------------------------------------------------------------------------
module dkcs_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_smooth_a,
  input wire        out_filter_ready
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_filter_ready |=> out_filter_ready) else $error("filter_ready dropped");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_smooth_a))
    else $error("result changed while waiting");
endmodule

bind diagonal_kalman_coef_smoother_core dkcs_checker u_dkcs_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_smooth_a(out_smooth_a), .out_filter_ready(out_filter_ready)
);
`default_nettype wire
